>>> hdl/gda_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date block.
// No dependencies; every other file refers to it by scoped names.
package gda_pkg;

   // Operation codes carried by each request word
   typedef enum logic [1:0] {
      OP_ADD_DAYS    = 2'd0,
      OP_ADD_YEAR    = 2'd1,
      OP_NEXT_MONDAY = 2'd2,
      OP_HOLD        = 2'd3
   } op_type;

   localparam logic [13:0] YEAR_MIN   = 14'd1;
   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [3:0]  MONTH_MIN  = 4'd1;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [3:0]  MONTH_FEB  = 4'd2;
   localparam logic [4:0]  DAY_MIN    = 5'd1;
   localparam logic [4:0]  DAY_LEAP   = 5'd29;
   localparam logic [4:0]  DAY_FEB_28 = 5'd28;
   localparam logic [8:0]  NDAYS_MAX  = 9'd365;
   localparam logic [8:0]  YEAR_DAYS  = 9'd365;
   localparam logic [2:0]  WDAY_MON   = 3'd1;

   // Reciprocal multipliers: y / 100 for y up to 10000, x / 7 for 15-bit x
   localparam logic [12:0] DIV100_MUL = 13'd5243;
   localparam logic [15:0] MOD7_MUL   = 16'd37450;

   // Front end to day-of-year stage
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [8:0]  ndays;
      logic        leap0;
      logic        leap1;
      logic [14:0] wsum;
   } front_type;

   // Day-of-year stage to calendar back end
   typedef struct packed {
      logic        valid;
      logic        use_cal;
      logic [13:0] year_f;
      logic        leap_f;
      logic [8:0]  doy;
      logic [3:0]  alt_month;
      logic [4:0]  alt_day;
      logic [9:0]  wsum;
   } mid_type;

   // Quotient by 100 through a reciprocal multiply
   function automatic logic [6:0] div100(input logic [13:0] y);
      logic [26:0] prod;
      prod = 27'(y) * 27'(DIV100_MUL);
      return prod[25:19];
   endfunction

   // Leap test from the year and its quotient by 100
   function automatic logic is_leap(input logic [13:0] y, input logic [6:0] q);
      logic [13:0] rem;
      rem = y - 14'(q) * 14'd100;
      return ((y[1:0] == 2'b00) && (rem != 14'd0)) ||
             ((rem == 14'd0) && (q[1:0] == 2'b00));
   endfunction

   // Remainder by 7 of a 15-bit value
   function automatic logic [2:0] mod7(input logic [14:0] x);
      logic [30:0] prod;
      logic [12:0] quo;
      logic [14:0] rest;
      prod = 31'(x) * 31'(MOD7_MUL);
      quo  = prod[30:18];
      rest = x - 15'(quo) * 15'd7;
      return rest[2:0];
   endfunction

   // Days in the year before the first of the month
   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] base;
      unique case (m)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && (m > MONTH_FEB)) ? 1 : 0);
   endfunction

   // Length of the month
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd2:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   // Month offset of the weekday formula
   function automatic logic [2:0] sak_offset(input logic [3:0] m);
      logic [2:0] t;
      unique case (m)
         4'd1:    t = 3'd0;
         4'd2:    t = 3'd3;
         4'd3:    t = 3'd2;
         4'd4:    t = 3'd5;
         4'd5:    t = 3'd0;
         4'd6:    t = 3'd3;
         4'd7:    t = 3'd5;
         4'd8:    t = 3'd1;
         4'd9:    t = 3'd4;
         4'd10:   t = 3'd6;
         4'd11:   t = 3'd2;
         4'd12:   t = 3'd4;
         default: t = 3'd0;
      endcase
      return t;
   endfunction

endpackage

>>> hdl/gda_front.sv
// Front end: clamps the request word, finds leap years and the weekday sum.
// Two register stages. Depends on gda_pkg.
module gda_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [1:0]         in_op,
   input  logic [13:0]        in_year,
   input  logic [3:0]         in_month,
   input  logic [4:0]         in_day,
   input  logic [8:0]         in_ndays,
   output gda_pkg::front_type front_out
);

   logic [13:0]      year_cl;
   logic [3:0]       month_cl;
   logic [8:0]       ndays_cl;

   logic             s1_valid_ff;
   gda_pkg::op_type  s1_op_ff;
   logic [13:0]      s1_year_ff;
   logic [3:0]       s1_month_ff;
   logic [4:0]       s1_day_ff;
   logic [8:0]       s1_ndays_ff;
   logic [6:0]       s1_q0_ff, s1_q0_in;
   logic [6:0]       s1_qm_ff, s1_qm_in;
   logic [6:0]       s1_qp_ff, s1_qp_in;

   logic             leap0, leap1;
   logic [4:0]       lim, day_cl;
   logic [13:0]      ys;
   logic [6:0]       qs;
   gda_pkg::front_type s2_ff, s2_in;

   // Clamp year, month and offset; divide the neighbouring years by 100
   always_comb begin
      if (in_year < gda_pkg::YEAR_MIN) year_cl = gda_pkg::YEAR_MIN;
      else if (in_year > gda_pkg::YEAR_MAX) year_cl = gda_pkg::YEAR_MAX;
      else year_cl = in_year;
      if (in_month < gda_pkg::MONTH_MIN) month_cl = gda_pkg::MONTH_MIN;
      else if (in_month > gda_pkg::MONTH_MAX) month_cl = gda_pkg::MONTH_MAX;
      else month_cl = in_month;
      ndays_cl = (in_ndays > gda_pkg::NDAYS_MAX) ? gda_pkg::NDAYS_MAX : in_ndays;
      s1_q0_in = gda_pkg::div100(year_cl);
      s1_qm_in = gda_pkg::div100(year_cl - 14'd1);
      s1_qp_in = gda_pkg::div100(year_cl + 14'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= gda_pkg::op_type'(in_op);
      s1_year_ff  <= year_cl;
      s1_month_ff <= month_cl;
      s1_day_ff   <= in_day;
      s1_ndays_ff <= ndays_cl;
      s1_q0_ff    <= s1_q0_in;
      s1_qm_ff    <= s1_qm_in;
      s1_qp_ff    <= s1_qp_in;
   end

   // Leap flags, day clamp and the weekday sum before reduction by 7
   always_comb begin
      leap0  = gda_pkg::is_leap(s1_year_ff, s1_q0_ff);
      leap1  = gda_pkg::is_leap(s1_year_ff + 14'd1, s1_qp_ff);
      lim    = gda_pkg::month_len(s1_month_ff, leap0);
      if (s1_day_ff < gda_pkg::DAY_MIN) day_cl = gda_pkg::DAY_MIN;
      else if (s1_day_ff > lim) day_cl = lim;
      else day_cl = s1_day_ff;
      if (s1_month_ff < 4'd3) begin
         ys = s1_year_ff - 14'd1;
         qs = s1_qm_ff;
      end else begin
         ys = s1_year_ff;
         qs = s1_q0_ff;
      end
      s2_in.valid = s1_valid_ff;
      s2_in.op    = s1_op_ff;
      s2_in.year  = s1_year_ff;
      s2_in.month = s1_month_ff;
      s2_in.day   = day_cl;
      s2_in.ndays = s1_ndays_ff;
      s2_in.leap0 = leap0;
      s2_in.leap1 = leap1;
      s2_in.wsum  = 15'(ys) + 15'(ys[13:2]) - 15'(qs) + 15'(qs[6:2])
                  + 15'(gda_pkg::sak_offset(s1_month_ff)) + 15'(day_cl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff.op    <= s2_in.op;
      s2_ff.year  <= s2_in.year;
      s2_ff.month <= s2_in.month;
      s2_ff.day   <= s2_in.day;
      s2_ff.ndays <= s2_in.ndays;
      s2_ff.leap0 <= s2_in.leap0;
      s2_ff.leap1 <= s2_in.leap1;
      s2_ff.wsum  <= s2_in.wsum;
   end

   assign front_out = s2_ff;

endmodule

>>> hdl/gda_doy.sv
// Day-of-year stages: input weekday, day of year, offset addition and year carry.
// Two register stages. Depends on gda_pkg.
module gda_doy (
   input  logic               clock,
   input  logic               reset,
   input  gda_pkg::front_type front_in,
   output gda_pkg::mid_type   mid_out
);

   logic             s3_valid_ff;
   gda_pkg::op_type  s3_op_ff;
   logic [13:0]      s3_year_ff;
   logic [3:0]       s3_month_ff;
   logic [4:0]       s3_day_ff;
   logic [8:0]       s3_ndays_ff;
   logic             s3_leap0_ff, s3_leap1_ff;
   logic [2:0]       s3_wday_ff, s3_wday_in;
   logic [8:0]       s3_doy_ff, s3_doy_in;

   logic [8:0]       step;
   logic [2:0]       delta_year;
   logic [8:0]       delta;
   logic [9:0]       total, ylen;
   logic             carry;
   gda_pkg::mid_type s4_ff, s4_in;

   // Reduce the weekday sum and find the day of the year
   always_comb begin
      s3_wday_in = gda_pkg::mod7(front_in.wsum);
      s3_doy_in  = gda_pkg::cum_days(front_in.month, front_in.leap0)
                 + 9'(front_in.day);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= front_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_op_ff    <= front_in.op;
      s3_year_ff  <= front_in.year;
      s3_month_ff <= front_in.month;
      s3_day_ff   <= front_in.day;
      s3_ndays_ff <= front_in.ndays;
      s3_leap0_ff <= front_in.leap0;
      s3_leap1_ff <= front_in.leap1;
      s3_wday_ff  <= s3_wday_in;
      s3_doy_ff   <= s3_doy_in;
   end

   // Pick the day step, add it, carry into the next year
   always_comb begin
      if (s3_wday_ff == 3'd0) step = 9'd1;
      else if (s3_wday_ff == gda_pkg::WDAY_MON) step = 9'd0;
      else step = 9'(4'd8 - 4'(s3_wday_ff));

      // A year on shifts the weekday by the length of the year spanned
      if (s3_month_ff == gda_pkg::MONTH_FEB && s3_day_ff == gda_pkg::DAY_LEAP)
         delta_year = 3'd1;
      else if (s3_month_ff <= gda_pkg::MONTH_FEB)
         delta_year = s3_leap0_ff ? 3'd2 : 3'd1;
      else
         delta_year = s3_leap1_ff ? 3'd2 : 3'd1;

      s4_in.alt_month = s3_month_ff;
      s4_in.alt_day   = s3_day_ff;
      s4_in.use_cal   = 1'b0;
      unique case (s3_op_ff)
         gda_pkg::OP_ADD_DAYS: begin
            delta         = s3_ndays_ff;
            s4_in.use_cal = 1'b1;
         end
         gda_pkg::OP_NEXT_MONDAY: begin
            delta         = step;
            s4_in.use_cal = 1'b1;
         end
         gda_pkg::OP_ADD_YEAR: begin
            delta = 9'(delta_year);
            if (s3_month_ff == gda_pkg::MONTH_FEB && s3_day_ff == gda_pkg::DAY_LEAP)
               s4_in.alt_day = gda_pkg::DAY_FEB_28;
         end
         gda_pkg::OP_HOLD: begin
            delta = 9'd0;
         end
      endcase

      total = 10'(s3_doy_ff) + 10'(delta);
      ylen  = 10'(gda_pkg::YEAR_DAYS) + 10'(s3_leap0_ff);
      carry = s4_in.use_cal && (total > ylen);

      s4_in.valid  = s3_valid_ff;
      s4_in.doy    = carry ? 9'(total - ylen) : total[8:0];
      s4_in.leap_f = carry ? s3_leap1_ff : s3_leap0_ff;
      if (s3_op_ff == gda_pkg::OP_ADD_YEAR || carry)
         s4_in.year_f = s3_year_ff + 14'd1;
      else
         s4_in.year_f = s3_year_ff;
      s4_in.wsum = 10'(s3_wday_ff) + 10'(delta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else begin
         s4_ff.valid <= s4_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s4_ff.use_cal   <= s4_in.use_cal;
      s4_ff.year_f    <= s4_in.year_f;
      s4_ff.leap_f    <= s4_in.leap_f;
      s4_ff.doy       <= s4_in.doy;
      s4_ff.alt_month <= s4_in.alt_month;
      s4_ff.alt_day   <= s4_in.alt_day;
      s4_ff.wsum      <= s4_in.wsum;
   end

   assign mid_out = s4_ff;

endmodule

>>> hdl/gda_back.sv
// Back end: turns the day of the year into month and day, or passes the held date, and reduces the weekday.
// Two register stages, the last drives the result word. Depends on gda_pkg.
module gda_back (
   input  logic             clock,
   input  logic             reset,
   input  gda_pkg::mid_type mid_in,
   output logic             out_valid,
   output logic [13:0]      out_year,
   output logic [3:0]       out_month,
   output logic [4:0]       out_day,
   output logic [2:0]       out_weekday
);

   logic [3:0]  s5_month_ff, s5_month_in;
   logic [2:0]  s5_wday_ff, s5_wday_in;
   logic        s5_valid_ff;
   logic        s5_use_cal_ff;
   logic [13:0] s5_year_ff;
   logic        s5_leap_ff;
   logic [8:0]  s5_doy_ff;
   logic [3:0]  s5_alt_month_ff;
   logic [4:0]  s5_alt_day_ff;

   logic        s6_valid_ff;
   logic [13:0] s6_year_ff;
   logic [3:0]  s6_month_ff, s6_month_in;
   logic [4:0]  s6_day_ff, s6_day_in;
   logic [2:0]  s6_wday_ff;
   logic [8:0]  day_cal;

   // Count the month starts that the day of the year has passed
   always_comb begin
      s5_month_in = gda_pkg::MONTH_MIN;
      for (int k = 2; k <= 12; k++) begin
         if (mid_in.doy > gda_pkg::cum_days(4'(k), mid_in.leap_f))
            s5_month_in = s5_month_in + 4'd1;
      end
      s5_wday_in = gda_pkg::mod7(15'(mid_in.wsum));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= mid_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s5_month_ff     <= s5_month_in;
      s5_wday_ff      <= s5_wday_in;
      s5_use_cal_ff   <= mid_in.use_cal;
      s5_year_ff      <= mid_in.year_f;
      s5_leap_ff      <= mid_in.leap_f;
      s5_doy_ff       <= mid_in.doy;
      s5_alt_month_ff <= mid_in.alt_month;
      s5_alt_day_ff   <= mid_in.alt_day;
   end

   // Take the day within the month and choose the result date
   always_comb begin
      day_cal = s5_doy_ff - gda_pkg::cum_days(s5_month_ff, s5_leap_ff);
      if (s5_use_cal_ff) begin
         s6_month_in = s5_month_ff;
         s6_day_in   = day_cal[4:0];
      end else begin
         s6_month_in = s5_alt_month_ff;
         s6_day_in   = s5_alt_day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_year_ff  <= s5_year_ff;
      s6_month_ff <= s6_month_in;
      s6_day_ff   <= s6_day_in;
      s6_wday_ff  <= s5_wday_ff;
   end

   assign out_valid   = s6_valid_ff;
   assign out_year    = s6_year_ff;
   assign out_month   = s6_month_ff;
   assign out_day     = s6_day_ff;
   assign out_weekday = s6_wday_ff;

endmodule

>>> hdl/gregorian_date_arithmetic.sv
// Top level of the Gregorian date block: front end, day-of-year and back end stages.
// Depends on gda_pkg, gda_front, gda_doy and gda_back.
//
// The block takes one request word per clock and returns each result word in order,
// with rsp_valid high for one cycle. busy never rises, so start may be held high
// continuously; the rate of one word per cycle is set by the six register stages
// of the pipeline, which every word passes through. The receiver must capture
// each result in its strobe cycle.
module gregorian_date_arithmetic (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [13:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [8:0]  req_offset_days,
   output logic        rsp_valid,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [2:0]  rsp_weekday
);

   gda_pkg::front_type front;
   gda_pkg::mid_type   mid;
   logic               accept;

   // The pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   gda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_op     (req_op),
      .in_year   (req_in_year),
      .in_month  (req_in_month),
      .in_day    (req_in_day),
      .in_ndays  (req_offset_days),
      .front_out (front)
   );

   gda_doy u_doy (
      .clock    (clock),
      .reset    (reset),
      .front_in (front),
      .mid_out  (mid)
   );

   gda_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_in      (mid),
      .out_valid   (rsp_valid),
      .out_year    (rsp_out_year),
      .out_month   (rsp_out_month),
      .out_day     (rsp_out_day),
      .out_weekday (rsp_weekday)
   );

   // Every accepted word comes out as a result word
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("result word missing six cycles after accept");

   // Result month lies in the calendar
   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_month >= gda_pkg::MONTH_MIN) &&
                    (rsp_out_month <= gda_pkg::MONTH_MAX))
      else $error("result month out of range");

   // Result day is never zero
   a_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_day != 5'd0))
      else $error("result day is zero");

   // Weekday is reduced by 7
   a_wday: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= 3'd6))
      else $error("weekday out of range");

endmodule
